### rtl/aad_pkg.sv
// Shared types, constants and register codes of the analog activity detector.
package aad_pkg;

  // Fixed field widths.
  localparam int unsigned DATA_W      = 12;
  localparam int unsigned CH_IN_W     = 2;
  localparam int unsigned WLEN_W      = 10;
  localparam int unsigned THR_W       = 20;
  localparam int unsigned TOTAL_OUT_W = 20;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 20;

  // Default structural sizes.
  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned DEPTH_DEF    = 16;

  // Register reset values and output saturation limit.
  localparam logic [WLEN_W-1:0]      WLEN_RST  = 10'd50;
  localparam logic [THR_W-1:0]       THR_RST   = 20'd1000;
  localparam logic [TOTAL_OUT_W-1:0] TOTAL_MAX = 20'hFFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH   = 1'b0,
    REG_MUSIC_THRESHOLD = 1'b1
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_SCALE,
    ST_FINISH
  } state_e;

  // Operation select for the shared accumulator.
  typedef struct packed {
    logic clear;
    logic add;
    logic scale;
  } sum_ctrl_t;

endpackage

### rtl/analog_activity_detector_core.sv
// Top level of the per-channel moving-sum activity detector.
//
//  Channel  | Handshake                      | Beat contents
//  ---------+--------------------------------+-----------------------------------------
//  input    | in_valid_i / in_ready_o        | channel_i, sample_i
//  result   | out_valid_o / out_ready_i      | channel_out_o, sample_echo_o,
//           |                                | activity_total_o, evaluated_o,
//           |                                | music_detected_o
//  config   | cfg_we_i (no wait)             | cfg_idx_i, cfg_wdata_i
//
// An item for a present channel passes through WRITE, READ, DRAIN, SCALE and FINISH; its
// result comes from reading the channel's DEPTH stored deltas one per cycle through the
// single read port of the history memory into the shared accumulator. An item for an absent
// channel goes from IDLE straight to FINISH. A new item is accepted only in IDLE, after the
// previous one has finished. After reset a clearing pass writes zero to all CHANNELS * DEPTH
// history entries, one per cycle, with in_ready_o low. A stalled result waits in the output
// register; the next beat is accepted meanwhile and held back only at its final step.
module analog_activity_detector_core #(
  parameter int unsigned CHANNELS = aad_pkg::CHANNELS_DEF,
  parameter int unsigned DEPTH    = aad_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [aad_pkg::CH_IN_W-1:0]     channel_i,
  input  logic [aad_pkg::DATA_W-1:0]      sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [aad_pkg::CH_IN_W-1:0]     channel_out_o,
  output logic [aad_pkg::DATA_W-1:0]      sample_echo_o,
  output logic [aad_pkg::TOTAL_OUT_W-1:0] activity_total_o,
  output logic                            evaluated_o,
  output logic                            music_detected_o,
  input  logic                            cfg_we_i,
  input  logic [aad_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [aad_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import aad_pkg::*;

  localparam int unsigned ENTRIES = CHANNELS * DEPTH;
  localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned SUM_W   = DATA_W + SLOT_W;
  localparam int unsigned TOT_W   = SUM_W + 4;
  localparam int unsigned CMP_W   = (TOT_W > THR_W) ? TOT_W : THR_W;

  state_e state_q, state_d;

  // Configuration registers.
  logic [WLEN_W-1:0] wlen_q;
  logic [THR_W-1:0]  thr_q;

  // Per-channel state.
  logic [SLOT_W-1:0] slot_q  [CHANNELS];
  logic [DATA_W-1:0] prev_q  [CHANNELS];
  logic [WLEN_W-1:0] count_q [CHANNELS];
  logic              flag_q  [CHANNELS];

  // Current item.
  logic [CH_IN_W-1:0] ch_q;
  logic [DATA_W-1:0]  smp_q;
  logic [AW-1:0]      base_q;
  logic               ch_ok_q;
  logic [CH_W-1:0]    ch_idx;
  logic               ch_ok_in;

  // Sequencing.
  logic [AW-1:0]     clr_addr_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              rd_issued_q;
  logic              in_acc;
  logic              finish;

  // Memory and accumulator wiring.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  sum_ctrl_t         sum_ctrl;
  logic [TOT_W-1:0]  acc;

  // Delta, ring advance and window evaluation.
  logic [DATA_W-1:0] prev_cur;
  logic [DATA_W-1:0] delta;
  logic [SLOT_W:0]   slot_inc;
  logic [SLOT_W-1:0] slot_nxt;
  logic [CMP_W-1:0]  total_cmp;
  logic              above;
  logic              fire;
  logic [TOTAL_OUT_W-1:0] total_sat;

  // Output register.
  logic                   out_valid_q;
  logic [CH_IN_W-1:0]     out_ch_q;
  logic [DATA_W-1:0]      out_smp_q;
  logic [TOTAL_OUT_W-1:0] out_total_q;
  logic                   out_eval_q;
  logic                   out_music_q;

  assign ch_idx   = CH_W'(ch_q);
  assign ch_ok_in = (int'(channel_i) < CHANNELS);
  assign in_acc   = in_valid_i && in_ready_o;
  assign finish   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // Sequencer: next state and per-state controls.
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = base_q + AW'(slot_q[ch_idx]);
    mem_wdata      = delta;
    sum_ctrl       = '0;
    sum_ctrl.add   = rd_issued_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
        if (clr_addr_q == AW'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ch_ok_in ? ST_WRITE : ST_FINISH;
        end
      end
      ST_WRITE: begin
        mem_we         = 1'b1;
        sum_ctrl.clear = 1'b1;
        state_d        = ST_READ;
      end
      ST_READ: begin
        if (rd_idx_q == SLOT_W'(DEPTH - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        sum_ctrl.scale = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Clearing pass address and read index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      rd_idx_q    <= '0;
      rd_issued_q <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (state_q == ST_READ) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end else begin
        rd_idx_q <= '0;
      end
      rd_issued_q <= (state_q == ST_READ);
    end
  end

  assign mem_raddr = base_q + AW'(rd_idx_q);

  // Item capture at acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_ok_q <= 1'b0;
    end else if (in_acc) begin
      ch_ok_q <= ch_ok_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= channel_i;
      smp_q  <= sample_i;
      base_q <= AW'(int'(CH_W'(channel_i)) * DEPTH);
    end
  end

  // Absolute difference and ring position.
  always_comb begin
    prev_cur = prev_q[ch_idx];
    delta    = (smp_q > prev_cur) ? (smp_q - prev_cur) : (prev_cur - smp_q);
    slot_inc = {1'b0, slot_q[ch_idx]} + 1'b1;
    slot_nxt = (slot_inc == (SLOT_W + 1)'(DEPTH)) ? '0 : slot_inc[SLOT_W-1:0];
  end

  // Threshold test on the full-width total, saturated copy for the result.
  always_comb begin
    total_cmp = CMP_W'(acc);
    above     = total_cmp > CMP_W'(thr_q);
    fire      = count_q[ch_idx] >= wlen_q;
    total_sat = (total_cmp > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX : total_cmp[TOTAL_OUT_W-1:0];
  end

  // Per-channel state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        slot_q[c]  <= '0;
        prev_q[c]  <= '0;
        count_q[c] <= '0;
        flag_q[c]  <= 1'b0;
      end
    end else begin
      if (state_q == ST_WRITE) begin
        slot_q[ch_idx] <= slot_nxt;
        prev_q[ch_idx] <= smp_q;
      end
      if (finish && ch_ok_q) begin
        if (fire) begin
          count_q[ch_idx] <= '0;
          flag_q[ch_idx]  <= above;
        end else begin
          count_q[ch_idx] <= count_q[ch_idx] + 1'b1;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RST;
      thr_q  <= THR_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_WINDOW_LENGTH:   wlen_q <= cfg_wdata_i[WLEN_W-1:0];
        REG_MUSIC_THRESHOLD: thr_q  <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_ch_q  <= ch_q;
      out_smp_q <= smp_q;
      if (ch_ok_q) begin
        out_total_q <= total_sat;
        out_eval_q  <= fire;
        out_music_q <= fire ? above : flag_q[ch_idx];
      end else begin
        out_total_q <= '0;
        out_eval_q  <= 1'b0;
        out_music_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_out_o    = out_ch_q;
  assign sample_echo_o    = out_smp_q;
  assign activity_total_o = out_total_q;
  assign evaluated_o      = out_eval_q;
  assign music_detected_o = out_music_q;

  aad_hist_ram #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  aad_sum_unit #(
    .TOT_W (TOT_W)
  ) u_sum_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sum_ctrl),
    .delta_i (mem_rdata),
    .acc_o   (acc)
  );

  // An accepted beat keeps the input closed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // No memory read may still be landing in the accumulator while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_issued_q)
    else $error("accumulator busy while idle");

  // A result for an absent channel carries no activity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (int'(channel_out_o) >= CHANNELS) |->
      (activity_total_o == '0) && !evaluated_o && !music_detected_o)
    else $error("absent channel produced activity");

endmodule

### rtl/aad_hist_ram.sv
// Delta history memory: one write port and one registered read port.
module aad_hist_ram #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned AW      = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [aad_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [aad_pkg::DATA_W-1:0] rdata_o
);
  import aad_pkg::*;

  logic [DATA_W-1:0] mem [ENTRIES];
  logic [DATA_W-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/aad_sum_unit.sv
// Shared accumulator: clears, adds one stored delta, or scales the sum by ten.
module aad_sum_unit #(
  parameter int unsigned TOT_W = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  aad_pkg::sum_ctrl_t         ctrl_i,
  input  logic [aad_pkg::DATA_W-1:0] delta_i,
  output logic [TOT_W-1:0]           acc_o
);
  import aad_pkg::*;

  logic [TOT_W-1:0] acc_q, acc_d;
  logic [TOT_W-1:0] op_a, op_b;

  // One adder serves both operations: acc + delta, or 8*acc + 2*acc.
  always_comb begin
    op_a  = ctrl_i.scale ? (acc_q << 3) : acc_q;
    op_b  = ctrl_i.scale ? (acc_q << 1) : TOT_W'(delta_i);
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.add || ctrl_i.scale) begin
      acc_d = op_a + op_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
